/* rtl/core/pcea_pkg.sv */
package pcea_pkg;

	localparam int ID_W     = 12;
	localparam int ENERGY_W = 24;
	localparam int TIME_W   = 48;

	typedef logic [ID_W-1:0]     crystal_id_t;
	typedef logic [ENERGY_W-1:0] energy_t;
	typedef logic [TIME_W-1:0]   tstamp_t;

	// One table entry as it is kept in the entry memory.
	typedef struct packed {
		crystal_id_t id;
		energy_t     energy;
		tstamp_t     tstamp;
	} entry_t;

	// Request kinds on the input channel.
	localparam logic KIND_HIT = 1'b0;
	localparam logic KIND_EOE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	// Saturating 24-bit energy sum.
	function automatic energy_t sat_add(energy_t a, energy_t b);
		logic [ENERGY_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[ENERGY_W] ? '1 : sum[ENERGY_W-1:0];
	endfunction

endpackage

/* rtl/core/per_channel_energy_accumulator.sv */
// Hit request: written at once when the table is empty, otherwise the entries are
// scanned up to the matching entry, or up to the last entry for a new crystal, which
// is then appended or, when the table is full, dropped; one id compare per cycle.
// End-of-event request: a scan of the entries, then a flush; both can wait while
// the result port stalls. Results leave at one per cycle from the output register
// while the result port does not stall. A new request waits until the sequencer is idle.
// Reset (arst_n low, asynchronous): table empty, overflow clear, threshold 0.
module per_channel_energy_accumulator #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// Configuration: energy threshold register.
	input  logic                  cfg_we,
	input  pcea_pkg::energy_t     cfg_wdata,

	// Request channel.
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  kind,
	input  pcea_pkg::crystal_id_t crystal_id,
	input  pcea_pkg::energy_t     energy,
	input  pcea_pkg::tstamp_t     hit_time,

	// Result channel.
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic                  entry_valid,
	output pcea_pkg::crystal_id_t out_crystal_id,
	output pcea_pkg::energy_t     out_energy,
	output pcea_pkg::tstamp_t     out_time,
	output logic                  overflow,
	output logic                  last
);

	import pcea_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

	// Control state.
	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [CNT_W-1:0] entry_count_q, entry_count_d;
	logic             ovf_q, ovf_d;
	energy_t          thr_q;

	// Captured hit request, held while the table is searched.
	crystal_id_t      hit_id_q;
	energy_t          hit_energy_q;
	tstamp_t          hit_time_q;

	// Pending survivor: the most recent entry found at or above threshold is held back one
	// step so that the final one can be marked with last.
	logic             pend_valid_q, pend_valid_d;
	logic             pend_load;
	entry_t           pend_q;

	// Result register.
	logic             out_valid_q;
	logic             out_load;
	logic             out_free;
	logic             res_entry_valid_d, res_last_d;
	entry_t           res_entry_d;
	logic             res_entry_valid_q, res_last_q, res_ovf_q;
	entry_t           res_entry_q;

	// Entry memory.
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	entry_t           ram_wdata, ram_rdata;

	logic             accept;
	logic             last_idx;
	logic             id_match;
	logic             survive;
	logic [IDX_W-1:0] idx_next;

	pcea_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Requests are taken only when the sequencer is idle; the result register
	// decouples a waiting result from the next request.
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !out_valid_q || !result_stall;

	// The read data always belongs to entry idx_q while scanning or emitting.
	assign idx_next = idx_q + IDX_W'(1);
	assign last_idx = ((CNT_W'(idx_q) + CNT_W'(1)) == entry_count_q);
	assign id_match = (ram_rdata.id == hit_id_q);
	assign survive  = (ram_rdata.energy >= thr_q);

	always_comb begin
		state_d           = state_q;
		idx_d             = idx_q;
		entry_count_d     = entry_count_q;
		ovf_d             = ovf_q;
		pend_valid_d      = pend_valid_q;
		pend_load         = 1'b0;
		ram_we            = 1'b0;
		ram_waddr         = idx_q;
		ram_wdata         = ram_rdata;
		ram_raddr         = idx_q;
		out_load          = 1'b0;
		res_entry_valid_d = 1'b0;
		res_last_d        = 1'b0;
		res_entry_d       = pend_q;

		unique case (state_q)
			ST_IDLE: begin
				ram_raddr = '0;
				idx_d     = '0;
				if (accept) begin
					if (kind == KIND_HIT) begin
						if (entry_count_q == '0) begin
							// Empty table: the hit becomes the first entry at once.
							ram_we        = 1'b1;
							ram_waddr     = '0;
							ram_wdata     = '{id: crystal_id, energy: energy, tstamp: hit_time};
							entry_count_d = CNT_W'(1);
						end else begin
							state_d = ST_SCAN;
						end
					end else begin
						pend_valid_d = 1'b0;
						state_d      = (entry_count_q == '0) ? ST_FLUSH : ST_EMIT;
					end
				end
			end

			ST_SCAN: begin
				ram_raddr = idx_next;
				priority if (id_match) begin
					// Known crystal: accumulate energy and keep the earlier time.
					ram_we    = 1'b1;
					ram_waddr = idx_q;
					ram_wdata = '{
						id:     hit_id_q,
						energy: sat_add(ram_rdata.energy, hit_energy_q),
						tstamp: (hit_time_q < ram_rdata.tstamp) ? hit_time_q
						                                        : ram_rdata.tstamp
					};
					state_d   = ST_IDLE;
				end else if (last_idx) begin
					// New crystal: append, or drop and flag when the table is full.
					if (entry_count_q < FULL_CNT) begin
						ram_we        = 1'b1;
						ram_waddr     = entry_count_q[IDX_W-1:0];
						ram_wdata     = '{id: hit_id_q, energy: hit_energy_q,
						                  tstamp: hit_time_q};
						entry_count_d = entry_count_q + CNT_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_next;
				end
			end

			ST_EMIT: begin
				// A survivor can only move on when the previous one can be pushed out.
				if (!survive || !pend_valid_q || out_free) begin
					ram_raddr = idx_next;
					if (survive) begin
						pend_load    = 1'b1;
						pend_valid_d = 1'b1;
						if (pend_valid_q) begin
							out_load          = 1'b1;
							res_entry_valid_d = 1'b1;
							res_entry_d       = pend_q;
						end
					end
					if (last_idx) begin
						state_d = ST_FLUSH;
					end else begin
						idx_d = idx_next;
					end
				end else begin
					ram_raddr = idx_q;
				end
			end

			ST_FLUSH: begin
				if (out_free) begin
					// Final result of the event, or a single empty result.
					out_load          = 1'b1;
					res_last_d        = 1'b1;
					res_entry_valid_d = pend_valid_q;
					res_entry_d       = pend_valid_q ? pend_q : '0;
					pend_valid_d      = 1'b0;
					entry_count_d     = '0;
					ovf_d             = 1'b0;
					state_d           = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			entry_count_q <= '0;
			ovf_q         <= 1'b0;
			thr_q         <= '0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			idx_q         <= idx_d;
			entry_count_q <= entry_count_d;
			ovf_q         <= ovf_d;
			pend_valid_q  <= pend_valid_d;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_id_q     <= crystal_id;
			hit_energy_q <= energy;
			hit_time_q   <= hit_time;
		end
		if (pend_load) begin
			pend_q <= ram_rdata;
		end
		if (out_load) begin
			res_entry_valid_q <= res_entry_valid_d;
			res_last_q        <= res_last_d;
			res_ovf_q         <= ovf_q;
			res_entry_q       <= res_entry_d;
		end
	end

	assign result_valid   = out_valid_q;
	assign entry_valid    = res_entry_valid_q;
	assign out_crystal_id = res_entry_q.id;
	assign out_energy     = res_entry_q.energy;
	assign out_time       = res_entry_q.tstamp;
	assign overflow       = res_ovf_q;
	assign last           = res_last_q;

	// The table never holds more entries than it has rows.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= FULL_CNT)
		else $error("entry count exceeds table depth");

	// Every result that carries an entry passed the threshold.
	a_thr: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && entry_valid) |-> (out_energy >= thr_q))
		else $error("emitted entry below threshold");

	// An empty-event result is always the final one of its run.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !entry_valid) |-> last)
		else $error("empty result without last");

	// Finishing an event leaves the table empty and the overflow flag clear.
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && out_free) |=> (entry_count_q == '0 && !ovf_q))
		else $error("table not cleared at end of event");

endmodule

/* rtl/core/pcea_ram.sv */
module pcea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port, single read port, read data registered.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
